>>> hw/rtl/jci_pkg.sv
`default_nettype none

package jci_pkg;

  localparam int OPCODE_W = 3;
  localparam int ERR_W = 3;
  localparam int MASK_W = 5;
  localparam int CHAN_W = 3;
  localparam int HEAD_BYTES = 4;
  localparam int ACCESSORY_EXTRA = 34;
  localparam int CRC_FIRST = 3;
  localparam int CRC_LAST = 34;
  localparam int CRC_SPAN = CRC_LAST - CRC_FIRST + 1;
  localparam int CRC_IDX_W = $clog2(CRC_SPAN);

  localparam logic [7:0] CRC_POLY = 8'h85;
  localparam logic [7:0] CMD_INFO = 8'h00;
  localparam logic [7:0] CMD_STATE = 8'h01;
  localparam logic [7:0] CMD_ACCESSORY = 8'h03;
  localparam logic [7:0] INFO_BYTE1 = 8'h05;
  localparam logic [7:0] INFO_STATUS = 8'h02;
  localparam logic [7:0] STATUS_CLOCK = 8'h08;
  localparam logic [7:0] STATUS_PRESENT = 8'h04;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_CHANNEL = 3'd0,
    OP_WR_NIBBLE  = 3'd1,
    OP_RD_RECEIVE = 3'd2,
    OP_RD_STATUS  = 3'd3,
    OP_RD_CHANNEL = 3'd4,
    OP_RD_ERROR   = 3'd5,
    OP_WR_CONTROL = 3'd6
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 3'd0,
    ERR_CHANNEL  = 3'd1,
    ERR_COMMAND  = 3'd2,
    ERR_NO_DEV   = 3'd3,
    ERR_OVERFLOW = 3'd4
  } err_t;

  typedef logic [7:0] crc_pow_t [CRC_SPAN];

  // a * b mod the crc polynomial
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00) ^ (b[i] ? a : 8'h00);
    end
    return r;
  endfunction

  // weight of each crc byte position: x^(8*(CRC_LAST+1-pos)) mod poly
  function automatic crc_pow_t crc_pow_table();
    crc_pow_t t;
    logic [7:0] r;
    r = 8'h01;
    for (int m = 1; m <= CRC_SPAN; m++) begin
      for (int b = 0; b < 8; b++) begin
        r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      end
      t[CRC_SPAN - m] = r;
    end
    return t;
  endfunction

  localparam crc_pow_t CRC_POW = crc_pow_table();

endpackage

`default_nettype wire

>>> hw/rtl/joybus_channel_interface_top.sv
// transfers pass one input register and one result register, with a skid for output stalls
// one transfer per cycle unless stalled; the byte store is a memory prefetched at the pointer
// accessory crc is a running sum per byte position, so completion takes the crc from the sum
// reset (rst, synchronous): store empty, pointer zero, command mode, no channel, mask 1
`default_nettype none

module joybus_channel_interface_top #(
  parameter int CHANNEL_COUNT = 5,
  parameter int STORE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jci_pkg::MASK_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jci_pkg::OPCODE_W-1:0]  opcode,
  input  logic [7:0]                    write_value,
  input  logic [31:0]                   buttons,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    read_value,
  output logic [jci_pkg::ERR_W-1:0]     error_code
);
  import jci_pkg::*;

  localparam int PW = $clog2(STORE_BYTES + 1);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int EW = $clog2(STORE_BYTES + ACCESSORY_EXTRA + 2);

  // configuration
  logic [MASK_W-1:0] mask;

  // input register
  logic                iv;
  logic [OPCODE_W-1:0] i_op;
  logic [7:0]          i_wv;
  logic [31:0]         i_bt;

  // port state
  logic [PW-1:0]     ptr, ptr_next;
  logic [EW-1:0]     exp_len, exp_len_next;
  logic              lnn, lnn_next;
  logic              dm, dm_next;
  logic [CHAN_W-1:0] sel, sel_next;
  logic              chosen, chosen_next;
  logic [7:0]        acc, acc_next;
  logic [7:0]        head [HEAD_BYTES];
  logic [7:0]        head_next [HEAD_BYTES];

  // byte store above the head bytes
  logic [7:0]             mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid;
  logic                   mem_we;
  logic                   clr;
  logic [AW-1:0]          raddr, waddr;
  logic [7:0]             rd_q, fwd_data;
  logic                   fwd_hit, rd_vld;

  // output register and skid
  logic             ov, sv;
  logic [7:0]       o_rv, s_rv;
  logic [ERR_W-1:0] o_err, s_err;
  logic             advance, out_take;
  logic [7:0]       res_rv;
  err_t             res_err;

  // datapath
  logic [7:0]           cur, cur_mem, upd_val, contrib, byte_val, cmd;
  logic [3:0]           nib;
  logic [CHAN_W-1:0]    ch_val;
  logic                 pos_ok, present, in_crc;
  logic [CRC_IDX_W-1:0] crc_idx;
  logic [7:0]           mask_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= MASK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      mask <= cfg_data;
    end
  end

  // handshake
  assign advance  = iv && !sv;
  assign out_take = !ov || !out_stall;
  assign in_stall = iv && sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        iv <= 1'b1;
      end else if (advance) begin
        iv <= 1'b0;
      end
      if (out_take) begin
        ov <= sv || advance;
        sv <= 1'b0;
      end else if (advance) begin
        sv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      i_op <= opcode;
      i_wv <= write_value;
      i_bt <= buttons;
    end
    if (out_take) begin
      o_rv  <= sv ? s_rv : res_rv;
      o_err <= sv ? s_err : res_err;
    end else if (advance) begin
      s_rv  <= res_rv;
      s_err <= res_err;
    end
  end

  assign out_valid  = ov;
  assign read_value = o_rv;
  assign error_code = o_err;

  // current byte at the pointer
  assign cur_mem = fwd_hit ? fwd_data : rd_q;
  assign cur = (ptr < PW'(HEAD_BYTES)) ? head[ptr[1:0]] : (rd_vld ? cur_mem : 8'h00);

  assign nib     = i_wv[3:0] & NIBBLE_MASK;
  assign ch_val  = i_wv[CHAN_W-1:0];
  assign pos_ok  = ptr < PW'(STORE_BYTES);
  assign byte_val = cur | {4'h0, nib};
  assign upd_val = lnn ? byte_val : {nib, 4'h0};
  assign cmd     = (ptr == '0) ? byte_val : head[0];

  assign mask_ext = 8'(mask);
  assign present  = chosen && mask_ext[sel];

  // crc weight of the change made at the pointer
  assign in_crc  = (ptr >= PW'(CRC_FIRST)) && (ptr <= PW'(CRC_LAST));
  assign crc_idx = CRC_IDX_W'(ptr - PW'(CRC_FIRST));
  assign contrib = in_crc ? gf_mul(cur ^ upd_val, CRC_POW[crc_idx]) : 8'h00;

  always_comb begin
    ptr_next     = ptr;
    exp_len_next = exp_len;
    lnn_next     = lnn;
    dm_next      = dm;
    sel_next     = sel;
    chosen_next  = chosen;
    acc_next     = acc;
    head_next    = head;
    mem_we       = 1'b0;
    clr          = 1'b0;
    res_rv       = 8'h00;
    res_err      = ERR_OK;
    if (advance) begin
      unique case (op_t'(i_op))
        OP_WR_CHANNEL: begin
          if (i_wv >= 8'(CHANNEL_COUNT)) begin
            res_err = ERR_CHANNEL;
          end else begin
            sel_next     = ch_val;
            chosen_next  = 1'b1;
            clr          = 1'b1;
            dm_next      = 1'b0;
            head_next[0] = 8'h00;
            head_next[1] = 8'h00;
            head_next[2] = 8'h00;
            head_next[3] = 8'h00;
            acc_next     = 8'h00;
          end
        end
        OP_WR_NIBBLE: begin
          if (!pos_ok) begin
            res_err = ERR_OVERFLOW;
          end else if (!lnn) begin
            if (ptr < PW'(HEAD_BYTES)) begin
              head_next[ptr[1:0]] = upd_val;
            end else begin
              mem_we = 1'b1;
            end
            acc_next = acc ^ contrib;
            lnn_next = 1'b1;
          end else if (!dm) begin
            priority if (cmd == CMD_INFO || cmd == CMD_STATE) begin
              if (!present) begin
                res_err = ERR_NO_DEV;
              end else begin
                clr      = 1'b1;
                lnn_next = 1'b0;
                if (cmd == CMD_INFO) begin
                  head_next[0] = CMD_INFO;
                  head_next[1] = INFO_BYTE1;
                  head_next[2] = INFO_STATUS;
                  head_next[3] = 8'h00;
                  acc_next     = 8'h00;
                end else begin
                  head_next[0] = i_bt[7:0];
                  head_next[1] = i_bt[15:8];
                  head_next[2] = i_bt[23:16];
                  head_next[3] = i_bt[31:24];
                  acc_next     = gf_mul(i_bt[31:24], CRC_POW[0]);
                end
              end
            end else if (cmd == CMD_ACCESSORY) begin
              if (ptr < PW'(HEAD_BYTES)) begin
                head_next[ptr[1:0]] = upd_val;
              end else begin
                mem_we = 1'b1;
              end
              acc_next     = acc ^ contrib;
              ptr_next     = ptr + PW'(1);
              exp_len_next = EW'(ptr) + EW'(ACCESSORY_EXTRA + 1);
              dm_next      = 1'b1;
              lnn_next     = 1'b0;
            end else begin
              res_err = ERR_COMMAND;
            end
          end else if (EW'(ptr) + EW'(1) == exp_len) begin
            priority if (head[0] != CMD_ACCESSORY) begin
              res_err = ERR_COMMAND;
            end else if (!present) begin
              res_err = ERR_NO_DEV;
            end else begin
              clr          = 1'b1;
              head_next[0] = acc ^ contrib;
              head_next[1] = 8'h00;
              head_next[2] = 8'h00;
              head_next[3] = 8'h00;
              acc_next     = 8'h00;
              dm_next      = 1'b0;
              lnn_next     = 1'b0;
            end
          end else begin
            if (ptr < PW'(HEAD_BYTES)) begin
              head_next[ptr[1:0]] = upd_val;
            end else begin
              mem_we = 1'b1;
            end
            acc_next = acc ^ contrib;
            ptr_next = ptr + PW'(1);
            lnn_next = 1'b0;
          end
        end
        OP_RD_RECEIVE: begin
          if (!pos_ok) begin
            res_err = ERR_OVERFLOW;
          end else if (!lnn) begin
            res_rv   = {4'h0, cur[7:4]};
            lnn_next = 1'b1;
          end else begin
            res_rv   = {4'h0, cur[3:0]};
            ptr_next = ptr + PW'(1);
            lnn_next = 1'b0;
          end
        end
        OP_RD_STATUS: begin
          res_rv = STATUS_CLOCK | (present ? STATUS_PRESENT : 8'h00);
        end
        OP_RD_CHANNEL: begin
          res_rv = 8'(sel);
        end
        OP_RD_ERROR, OP_WR_CONTROL: begin
          res_rv = 8'h00;
        end
        default: begin
          res_rv = 8'h00;
        end
      endcase
      if (clr) begin
        ptr_next     = '0;
        exp_len_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      exp_len <= '0;
      lnn     <= 1'b0;
      dm      <= 1'b0;
      sel     <= '0;
      chosen  <= 1'b0;
      acc     <= 8'h00;
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head[i] <= 8'h00;
      end
    end else begin
      ptr     <= ptr_next;
      exp_len <= exp_len_next;
      lnn     <= lnn_next;
      dm      <= dm_next;
      sel     <= sel_next;
      chosen  <= chosen_next;
      acc     <= acc_next;
      head    <= head_next;
    end
  end

  // store memory, read prefetched at the next pointer
  assign raddr = ptr_next[AW-1:0];
  assign waddr = ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= upd_val;
    end
    rd_q     <= mem[raddr];
    fwd_data <= upd_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (clr) begin
        valid <= '0;
      end else if (mem_we) begin
        valid[waddr] <= 1'b1;
      end
      rd_vld  <= !clr && (valid[raddr] || (mem_we && waddr == raddr));
      fwd_hit <= mem_we && waddr == raddr;
    end
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid full while output register empty");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst) in_stall |-> iv)
    else $error("input stalled with empty input register");

  a_data_mode_ptr: assert property (@(posedge clk) disable iff (rst) dm |-> (ptr != '0))
    else $error("data mode with pointer at zero");

  a_channel_clears: assert property (@(posedge clk) disable iff (rst)
      (advance && i_op == OP_WR_CHANNEL && i_wv < 8'(CHANNEL_COUNT))
      |=> (ptr == '0 && !dm && chosen && acc == 8'h00))
    else $error("channel select did not clear the store");
`endif

endmodule

`default_nettype wire

>>> tb/sv/joybus_channel_interface_top_tb.sv
module joybus_channel_interface_top_tb;
  import jci_pkg::*;

  localparam int CHANNEL_COUNT = 5;
  localparam int STORE_BYTES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_ITEMS = 50;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MASK_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [7:0] write_value = '0;
  logic [31:0] buttons = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] read_value;
  logic [ERR_W-1:0] error_code;

  joybus_channel_interface_top #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .STORE_BYTES(STORE_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .write_value(write_value),
    .buttons(buttons),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .error_code(error_code)
  );

  typedef struct packed {
    logic [7:0] rv;
    err_t err;
  } answer_t;

  typedef struct packed {
    op_t op;
    logic [7:0] wv;
    logic [31:0] btn;
    logic [7:0] reps;
    bit typed;
    logic [7:0] rv;
    err_t err;
  } row_t;

  localparam int ROWS = 30;
  localparam row_t PLAN [ROWS] = '{
    '{OP_RD_STATUS,  8'h00, 32'h0,        8'd1,   1'b1, STATUS_CLOCK, ERR_OK},
    '{OP_RD_CHANNEL, 8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'hF0, 32'h0,        8'd1,   1'b1, 8'h00, ERR_NO_DEV},
    '{OP_WR_CHANNEL, 8'hFF, 32'h0,        8'd1,   1'b1, 8'h00, ERR_CHANNEL},
    '{OP_WR_CHANNEL, 8'h05, 32'h0,        8'd1,   1'b1, 8'h00, ERR_CHANNEL},
    '{OP_WR_CHANNEL, 8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_RD_STATUS,  8'h00, 32'h0,        8'd1,   1'b1, STATUS_CLOCK | STATUS_PRESENT, ERR_OK},
    '{OP_WR_NIBBLE,  8'h01, 32'hFFFFFFFF, 8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_RD_RECEIVE, 8'h00, 32'h0,        8'd8,   1'b0, 8'h00, ERR_OK},
    '{OP_WR_CHANNEL, 8'h04, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_RD_STATUS,  8'h00, 32'h0,        8'd1,   1'b1, STATUS_CLOCK, ERR_OK},
    '{OP_RD_CHANNEL, 8'h00, 32'h0,        8'd1,   1'b1, 8'h04, ERR_OK},
    '{OP_WR_NIBBLE,  8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_NO_DEV},
    '{OP_WR_CHANNEL, 8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'h0A, 32'h0,        8'd1,   1'b1, 8'h00, ERR_COMMAND},
    '{OP_RD_RECEIVE, 8'h00, 32'h0,        8'd1,   1'b0, 8'h00, ERR_OK},
    '{OP_WR_CHANNEL, 8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'h03, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_NIBBLE,  8'h5A, 32'h0,        8'd68,  1'b0, 8'h00, ERR_OK},
    '{OP_RD_RECEIVE, 8'h00, 32'h0,        8'd2,   1'b0, 8'h00, ERR_OK},
    '{OP_RD_ERROR,   8'hFF, 32'hFFFFFFFF, 8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_CONTROL, 8'hFF, 32'hFFFFFFFF, 8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_WR_CHANNEL, 8'h01, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OK},
    '{OP_RD_RECEIVE, 8'h00, 32'h0,        8'd128, 1'b0, 8'h00, ERR_OK},
    '{OP_RD_RECEIVE, 8'h00, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OVERFLOW},
    '{OP_WR_NIBBLE,  8'h07, 32'h0,        8'd1,   1'b1, 8'h00, ERR_OVERFLOW},
    '{OP_RD_STATUS,  8'h00, 32'h0,        8'd1,   1'b1, STATUS_CLOCK, ERR_OK}
  };

  // shadow of the port state
  logic [7:0] shadow_store [STORE_BYTES];
  int shadow_ptr;
  int shadow_len;
  bit shadow_low_next;
  bit shadow_data_mode;
  logic [CHAN_W-1:0] shadow_chan;
  bit shadow_chan_set;
  logic [7:0] shadow_crc;
  logic [MASK_W-1:0] shadow_mask;

  answer_t answers_due [$];
  int mismatches = 0;
  int counted = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_shadow_store();
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_ptr = 0;
    shadow_len = 0;
  endfunction

  function automatic bit device_attached();
    return shadow_chan_set && shadow_mask[shadow_chan];
  endfunction

  function automatic logic [7:0] crc8_shift(logic [7:0] c, logic [7:0] b);
    bit fb;
    for (int j = 7; j >= 0; j--) begin
      fb = c[7];
      c = {c[6:0], b[j]};
      if (fb) c ^= CRC_POLY;
    end
    return c;
  endfunction

  function automatic err_t transmit_nibble(logic [3:0] nib, logic [31:0] btn);
    int pos;
    logic [7:0] b;
    logic [7:0] cmd;
    logic [7:0] crc;
    pos = shadow_ptr;
    if (pos >= STORE_BYTES) return ERR_OVERFLOW;
    if (!shadow_low_next) begin
      shadow_store[pos] = {nib, 4'h0};
      shadow_low_next = 1'b1;
      return ERR_OK;
    end
    b = shadow_store[pos] | {4'h0, nib};
    if (!shadow_data_mode) begin
      cmd = (pos == 0) ? b : shadow_store[0];
      if (cmd == CMD_INFO) begin
        if (!device_attached()) return ERR_NO_DEV;
        clear_shadow_store();
        shadow_store[0] = CMD_INFO;
        shadow_store[1] = INFO_BYTE1;
        shadow_store[2] = INFO_STATUS;
      end else if (cmd == CMD_STATE) begin
        if (!device_attached()) return ERR_NO_DEV;
        clear_shadow_store();
        for (int i = 0; i < 4; i++) shadow_store[i] = btn[8*i +: 8];
      end else if (cmd == CMD_ACCESSORY) begin
        shadow_store[pos] = b;
        shadow_ptr = pos + 1;
        shadow_len = shadow_ptr + ACCESSORY_EXTRA;
        shadow_data_mode = 1'b1;
      end else begin
        return ERR_COMMAND;
      end
      shadow_low_next = 1'b0;
      return ERR_OK;
    end
    if (pos + 1 == shadow_len) begin
      if (shadow_store[0] != CMD_ACCESSORY) return ERR_COMMAND;
      if (!device_attached()) return ERR_NO_DEV;
      shadow_store[pos] = b;
      crc = 8'h00;
      for (int i = CRC_FIRST; i <= CRC_LAST; i++) crc = crc8_shift(crc, shadow_store[i]);
      crc = crc8_shift(crc, 8'h00);
      clear_shadow_store();
      shadow_store[0] = crc;
      shadow_crc = crc;
      shadow_data_mode = 1'b0;
    end else begin
      shadow_store[pos] = b;
      shadow_ptr = pos + 1;
    end
    shadow_low_next = 1'b0;
    return ERR_OK;
  endfunction

  function automatic answer_t predict_access(op_t op, logic [7:0] wv, logic [31:0] btn);
    answer_t a;
    a.rv = 8'h00;
    a.err = ERR_OK;
    case (op)
      OP_WR_CHANNEL: begin
        if (wv >= CHANNEL_COUNT) begin
          a.err = ERR_CHANNEL;
        end else begin
          shadow_chan = wv[CHAN_W-1:0];
          shadow_chan_set = 1'b1;
          clear_shadow_store();
          shadow_data_mode = 1'b0;
        end
      end
      OP_WR_NIBBLE: a.err = transmit_nibble(wv[3:0], btn);
      OP_RD_RECEIVE: begin
        if (shadow_ptr >= STORE_BYTES) begin
          a.err = ERR_OVERFLOW;
        end else if (!shadow_low_next) begin
          a.rv = {4'h0, shadow_store[shadow_ptr][7:4]};
          shadow_low_next = 1'b1;
        end else begin
          a.rv = {4'h0, shadow_store[shadow_ptr][3:0]};
          shadow_ptr++;
          shadow_low_next = 1'b0;
        end
      end
      OP_RD_STATUS: a.rv = STATUS_CLOCK | (device_attached() ? STATUS_PRESENT : 8'h00);
      OP_RD_CHANNEL: a.rv = {{(8-CHAN_W){1'b0}}, shadow_chan};
      default: ;
    endcase
    return a;
  endfunction

  task automatic send(input op_t op, input logic [7:0] wv, input logic [31:0] btn,
                      input bit typed = 1'b0, input logic [7:0] t_rv = 8'h00,
                      input err_t t_err = ERR_OK);
    answer_t a;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    write_value <= wv;
    buttons <= btn;
    do @(posedge clk); while (in_stall);
    a = predict_access(op, wv, btn);
    if (typed) begin
      a.rv = t_rv;
      a.err = t_err;
    end
    answers_due.push_back(a);
    if (op != OP_RD_ERROR && op != OP_WR_CONTROL) counted++;
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    drain_answers();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_mask = m;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send(OP_WR_NIBBLE, {4'($urandom), b[7:4]}, $urandom);
    send(OP_WR_NIBBLE, {4'($urandom), b[3:0]}, $urandom);
  endtask

  task automatic take_nibbles(input int n);
    repeat (n) send(OP_RD_RECEIVE, 8'($urandom), $urandom);
  endtask

  // realign the nibble phase, then pick a channel so the store starts empty
  task automatic fresh_channel();
    if (shadow_low_next) take_nibbles(1);
    send(OP_WR_CHANNEL, 8'($urandom_range(CHANNEL_COUNT - 1)), $urandom);
  endtask

  task automatic accessory_write();
    int pick;
    put_byte(CMD_ACCESSORY);
    repeat (ACCESSORY_EXTRA) begin
      pick = $urandom_range(99);
      if (pick < 5) send(op_t'($urandom_range(OP_WR_CONTROL, OP_RD_STATUS)), 8'($urandom),
                         $urandom);
      else if (pick < 6) take_nibbles(1);
      put_byte(8'($urandom));
    end
    take_nibbles(2);
  endtask

  task automatic run_segment(input int quota);
    int stop;
    int pick;
    stop = counted + quota;
    while (counted < stop) begin
      pick = $urandom_range(99);
      if (pick >= 10 && pick < 76 && $urandom_range(4) != 0) fresh_channel();
      if (pick < 10) begin
        if ($urandom_range(4) == 0)
          send(OP_WR_CHANNEL, 8'($urandom_range(255, CHANNEL_COUNT)), $urandom);
        else
          send(OP_WR_CHANNEL, 8'($urandom_range(CHANNEL_COUNT - 1)), $urandom);
      end else if (pick < 28) begin
        put_byte(CMD_INFO);
        take_nibbles(6);
      end else if (pick < 46) begin
        put_byte(CMD_STATE);
        take_nibbles(8);
      end else if (pick < 66) begin
        accessory_write();
      end else if (pick < 76) begin
        put_byte(8'($urandom));
      end else if (pick < 78) begin
        take_nibbles(2 * STORE_BYTES + 2);
      end else begin
        repeat ($urandom_range(6, 1))
          send(op_t'($urandom_range(OP_WR_CONTROL)), 8'($urandom), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    answer_t due;
    if (!rst && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $error("result transfer with nothing pending: read_value %0h error_code %0d",
               read_value, error_code);
        mismatches++;
      end else begin
        due = answers_due.pop_front();
        if (read_value !== due.rv) begin
          $error("read_value expected %0h got %0h", due.rv, read_value);
          mismatches++;
        end
        if (error_code !== due.err) begin
          $error("error_code expected %0d got %0d", due.err, error_code);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    shadow_mask = 5'h01;
    clear_shadow_store();
    shadow_low_next = 1'b0;
    shadow_data_mode = 1'b0;
    shadow_chan = '0;
    shadow_chan_set = 1'b0;
    shadow_crc = 8'h00;
    send_idle = 16;
    recv_idle = 45;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < ROWS; i++) begin
      for (int k = 0; k < PLAN[i].reps; k++) begin
        send(PLAN[i].op, PLAN[i].wv, PLAN[i].btn, PLAN[i].typed, PLAN[i].rv, PLAN[i].err);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 16 : (ph == 1) ? 45 : 0;
      recv_idle = (ph == 0) ? 45 : (ph == 1) ? 16 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: write_mask(5'h1F);
          1: write_mask(5'h00);
          2: write_mask(5'($urandom));
          default: write_mask(5'h01);
        endcase
        run_segment(SEGMENT_ITEMS);
      end
    end

    drain_answers();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
